FILE: sv/ltfd_pkg.sv
// shared types and constants for the lens texture fetch and dither unit
// no dependencies
package ltfd_pkg;

	localparam int TEX_DIM    = 256;
	localparam int NUM_COLORS = 16;
	localparam int COLOR_AW   = $clog2(NUM_COLORS + 1);
	localparam int TEX_AW     = 16;
	localparam int MAX_LOG2   = 8;
	localparam int DATA_W     = 104;

	typedef enum logic [1:0] {
		ACT_TEXEL  = 2'd0,
		ACT_COLOR  = 2'd1,
		ACT_RENDER = 2'd2,
		ACT_FRAME  = 2'd3
	} action_t;

	localparam logic [2:0] MODE_DIRECT  = 3'd0;
	localparam logic [2:0] MODE_ORDERED = 3'd1;
	localparam logic [2:0] MODE_SKEWED  = 3'd2;
	localparam logic [2:0] MODE_SEMI    = 3'd3;
	localparam logic [2:0] MODE_INTER   = 3'd4;

	localparam logic [7:0] REG_MODE   = 8'd0;
	localparam logic [7:0] REG_SIZE   = 8'd1;
	localparam logic [7:0] REG_VIEW_X = 8'd2;
	localparam logic [7:0] REG_VIEW_Y = 8'd3;

	typedef enum logic {
		ST_IDLE,
		ST_FETCH
	} state_t;

	typedef struct packed {
		logic tex_we;
		logic color_we;
		logic phase_inc;
		logic render;
		logic out_load;
	} cmd_t;

endpackage

FILE: sv/ltfd_ctrl.sv
// controller state machine: request acceptance, fetch sequencing, output valid
// depends on ltfd_pkg
module ltfd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  ltfd_pkg::action_t    action,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output ltfd_pkg::cmd_t       cmd
);
	import ltfd_pkg::*;

	state_t state_q, state_d;
	logic   valid_q;
	logic   accept;
	logic   out_free;

	assign accept   = s_tvalid && (state_q == ST_IDLE);
	assign out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_RENDER) state_d = ST_FETCH;
			end
			ST_FETCH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready      = 1'b1;
				cmd.tex_we    = accept && action == ACT_TEXEL;
				cmd.color_we  = accept && action == ACT_COLOR;
				cmd.phase_inc = accept && action == ACT_FRAME;
				cmd.render    = accept && action == ACT_RENDER;
			end
			ST_FETCH: begin
				cmd.out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
		end
	end

endmodule

FILE: sv/ltfd_datapath.sv
// datapath: config registers, texture memory, color table, dither and output register
// depends on ltfd_pkg
module ltfd_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [7:0]                    cfg_index,
	input  logic [19:0]                   cfg_data,
	input  logic [ltfd_pkg::DATA_W-1:0]   s_tdata,
	input  ltfd_pkg::cmd_t                cmd,
	output logic [31:0]                   m_tdata
);
	import ltfd_pkg::*;

	logic [2:0]  mode_q;
	logic [3:0]  size_q;
	logic [19:0] view_x_q;
	logic [19:0] view_y_q;
	logic [1:0]  phase_q;

	logic [31:0] tex_mem [2**TEX_AW];
	logic [31:0] color_q [NUM_COLORS + 1];

	logic [15:0] in_index;
	logic [31:0] in_value;
	logic [15:0] in_dx;
	logic [15:0] in_dy;
	logic [11:0] in_sx;
	logic [11:0] in_sy;

	logic [3:0]  lg;
	logic [7:0]  mask;
	logic [11:0] sum_x;
	logic [11:0] sum_y;
	logic [7:0]  mx;
	logic [7:0]  my;
	logic [TEX_AW-1:0] rd_addr;

	logic [31:0] texel_q;
	logic        sx0_q;
	logic        sy0_q;
	logic        sy1_q;

	logic        px0;
	logic        py0;
	logic [3:0]  dth;
	logic [8:0]  csum;
	logic [4:0]  cidx;
	logic [COLOR_AW-1:0] csel;
	logic [31:0] pixel;

	assign in_index = s_tdata[15:0];
	assign in_value = s_tdata[47:16];
	assign in_dx    = s_tdata[63:48];
	assign in_dy    = s_tdata[79:64];
	assign in_sx    = s_tdata[91:80];
	assign in_sy    = s_tdata[103:92];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DIRECT;
			size_q   <= 4'(MAX_LOG2);
			view_x_q <= '0;
			view_y_q <= '0;
			phase_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MODE:   mode_q   <= cfg_data[2:0];
					REG_SIZE:   size_q   <= cfg_data[3:0];
					REG_VIEW_X: view_x_q <= cfg_data;
					REG_VIEW_Y: view_y_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.phase_inc) phase_q <= phase_q + 2'd1;
		end
	end

	// coordinate wrap and texel address
	assign lg    = (size_q > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : size_q;
	assign mask  = 8'((9'd1 << lg) - 9'd1);
	assign sum_x = view_x_q[11:0] + in_dx[11:0];
	assign sum_y = view_y_q[11:0] + in_dy[11:0];
	assign mx    = sum_x[11:4] & mask;
	assign my    = sum_y[11:4] & mask;
	assign rd_addr = TEX_AW'(32'(my) * TEX_DIM + 32'(mx));

	always_ff @(posedge clk) begin
		if (cmd.tex_we) tex_mem[in_index] <= in_value;
		if (cmd.render) texel_q <= tex_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.color_we && in_index <= 16'(NUM_COLORS))
			color_q[COLOR_AW'(in_index)] <= in_value;
		if (cmd.render) begin
			sx0_q <= in_sx[0];
			sy0_q <= in_sy[0];
			sy1_q <= in_sy[1];
		end
	end

	// 2x2 bayer pattern select
	always_comb begin
		px0 = sx0_q;
		py0 = sy0_q;
		case (mode_q)
			MODE_SKEWED: px0 = sx0_q ^ sy1_q;
			MODE_SEMI: begin
				px0 = sx0_q ^ phase_q[0];
				py0 = sy0_q ^ phase_q[0];
			end
			MODE_INTER: begin
				px0 = sx0_q ^ phase_q[1];
				py0 = sy0_q ^ phase_q[0];
			end
			default: ;
		endcase
	end

	assign dth  = {px0 ^ py0, py0, 2'b00};
	assign csum = {1'b0, texel_q[7:0]} + {5'b0, dth};
	assign cidx = (csum[8:4] > 5'(NUM_COLORS)) ? 5'(NUM_COLORS) : csum[8:4];
	assign csel = COLOR_AW'(cidx);

	always_comb begin
		case (mode_q)
			MODE_ORDERED, MODE_SKEWED, MODE_SEMI, MODE_INTER: pixel = color_q[csel];
			default: pixel = texel_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) m_tdata <= pixel;
	end

endmodule

FILE: sv/lens_texture_fetch_dither_unit.sv
// top level of the lens texture fetch and dither unit
// depends on ltfd_pkg, ltfd_ctrl, ltfd_datapath
//
// Texel writes, color writes and end-of-frame requests act as they are accepted.
// For a render request, the texel address is formed as the request is accepted,
// the registered texture memory read returns in the next cycle, and the color lookup
// then loads the output register. A new request is accepted while a finished pixel
// waits on the output; a render stalls in its fetch state only while the previous
// pixel is still not taken. Configuration writes are accepted every cycle and must
// only be issued while the unit is idle. Texture memory and color table contents are
// undefined until written.
module lens_texture_fetch_dither_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [7:0]                    cfg_index,
	input  logic [19:0]                   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// index, value, lens_dx, lens_dy, screen_x, screen_y
	input  logic [ltfd_pkg::DATA_W-1:0]   s_tdata,
	// action
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// pixel_color
	output logic [31:0]                   m_tdata
);
	import ltfd_pkg::*;

	cmd_t    cmd;
	action_t action;

	assign cfg_ready = 1'b1;
	assign action    = action_t'(s_tuser);

	ltfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (action),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ltfd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.m_tdata   (m_tdata)
	);

endmodule
